### src/dct_coefficient_quantizer_defines.svh
// Assertion macros shared by the quantizer RTL.
`ifndef DCT_COEFFICIENT_QUANTIZER_DEFINES_SVH
`define DCT_COEFFICIENT_QUANTIZER_DEFINES_SVH

// Checked on every clock edge outside reset.
`define DCTQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define DCTQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### src/dctq_pkg.sv
// Types and constants for the DCT coefficient quantizer.
package dctq_pkg;

   localparam int COEF_W      = 16;
   localparam int IDX_W       = 3;
   localparam int QNT_W       = 8;
   localparam int STEP_W      = 15;           // 121 * 255 fits
   localparam int MAG_W       = COEF_W + 1;   // magnitude of -32768
   localparam int DIV_STAGES  = 3;
   localparam int DIV_BITS    = 3;
   localparam int QUO_W       = DIV_STAGES * DIV_BITS;
   localparam int KIND_W      = 2;
   localparam int LEVEL_W     = 8;
   localparam int CSR_ADDR_W  = 2;

   localparam logic [QUO_W:0] QNT_POS_MAX = 10'd127;
   localparam logic [QUO_W:0] QNT_NEG_MAX = 10'd128;

   localparam logic [CSR_ADDR_W-1:0] REG_TABLE_KIND = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_LEVEL      = 2'd1;

   localparam logic [KIND_W-1:0] KIND_LUMA  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RAMP  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FLAT  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_TRIDI = 2'd3;

   localparam logic [KIND_W-1:0]  TABLE_KIND_RESET = KIND_LUMA;
   localparam logic [LEVEL_W-1:0] LEVEL_RESET      = 8'd1;

   localparam logic [6:0] LUMA_STEPS [64] = '{
      7'd16, 7'd11, 7'd10, 7'd16, 7'd24, 7'd40, 7'd51, 7'd61,
      7'd12, 7'd12, 7'd14, 7'd19, 7'd26, 7'd58, 7'd60, 7'd55,
      7'd14, 7'd13, 7'd16, 7'd24, 7'd40, 7'd57, 7'd69, 7'd56,
      7'd14, 7'd17, 7'd22, 7'd29, 7'd51, 7'd87, 7'd80, 7'd62,
      7'd18, 7'd22, 7'd37, 7'd56, 7'd68, 7'd109, 7'd103, 7'd77,
      7'd24, 7'd35, 7'd55, 7'd64, 7'd81, 7'd104, 7'd113, 7'd92,
      7'd49, 7'd64, 7'd78, 7'd87, 7'd103, 7'd121, 7'd120, 7'd101,
      7'd72, 7'd92, 7'd95, 7'd98, 7'd112, 7'd100, 7'd103, 7'd99
   };

   typedef struct packed {
      logic signed [COEF_W-1:0] coefficient;
      logic        [IDX_W-1:0]  row;
      logic        [IDX_W-1:0]  col;
   } req_type;

   typedef struct packed {
      logic signed [QNT_W-1:0] quantized;
      logic                    overflow;
   } rsp_type;

endpackage

### src/dct_coefficient_quantizer.sv
// Throughput: one coefficient per cycle when nothing stalls. An accepted req beat
//   passes a step-pick stage, three divide stages (3 quotient bits each, compare
//   and subtract) and a round/saturate output stage to become its rsp beat.
// Each stage holds its beat only while the one after it is full and stalled.
// Reset (synchronous) empties the pipeline and sets table_kind 0, level 1.
// Config writes are taken every cycle (csr_ready is always high).
`include "dct_coefficient_quantizer_defines.svh"

module dct_coefficient_quantizer #(
   parameter int FRACTION_BITS = 3
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  dctq_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output dctq_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dctq_pkg::CSR_ADDR_W-1:0]     csr_index,
   input  logic [dctq_pkg::LEVEL_W-1:0]        csr_wdata
);

   localparam int DEN_W = dctq_pkg::STEP_W + FRACTION_BITS;
   localparam int CMP_W = DEN_W + dctq_pkg::QUO_W + 1;
   localparam int NS    = dctq_pkg::DIV_STAGES;
   localparam int MW    = dctq_pkg::MAG_W;
   localparam int QW    = dctq_pkg::QUO_W;

   // configuration
   logic [dctq_pkg::KIND_W-1:0]  table_kind_ff;
   logic [dctq_pkg::LEVEL_W-1:0] level_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_kind_ff <= dctq_pkg::TABLE_KIND_RESET;
         level_ff      <= dctq_pkg::LEVEL_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dctq_pkg::REG_TABLE_KIND: table_kind_ff <= csr_wdata[dctq_pkg::KIND_W-1:0];
            dctq_pkg::REG_LEVEL:      level_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline storage: stage 0 after step pick, 1..NS after each divide stage
   logic          vld_ff  [0:NS];
   logic [MW-1:0] rem_ff  [0:NS];
   logic [QW-1:0] quo_ff  [0:NS];
   logic [DEN_W-1:0] den_ff [0:NS];
   logic          neg_ff  [0:NS];

   logic          vld_in  [0:NS];
   logic [MW-1:0] rem_in  [0:NS];
   logic [QW-1:0] quo_in  [0:NS];
   logic [DEN_W-1:0] den_in [0:NS];
   logic          neg_in  [0:NS];

   logic          rdy     [0:NS+1];

   logic              rsp_valid_ff, rsp_valid_in;
   dctq_pkg::rsp_type rsp_ff, rsp_in;

   // a stage may load when it is empty or its contents move on
   always_comb begin
      rdy[NS+1] = !rsp_valid_ff || !rsp_stall;
      for (int k = NS; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   assign req_stall = !rdy[0];

   // stage 0: step pick and coefficient magnitude
   always_comb begin
      logic [dctq_pkg::STEP_W-1:0] step;
      logic [dctq_pkg::STEP_W-1:0] luma_step;
      logic [dctq_pkg::STEP_W-1:0] ramp_step;
      logic [dctq_pkg::IDX_W:0]    rc_sum;
      logic [dctq_pkg::IDX_W-1:0]  diff;
      logic [dctq_pkg::STEP_W-1:0] level_x;

      level_x   = dctq_pkg::STEP_W'(level_ff);
      luma_step = dctq_pkg::STEP_W'(
                     dctq_pkg::LUMA_STEPS[{req_data.row, req_data.col}]) * level_x;
      rc_sum    = {1'b0, req_data.row} + {1'b0, req_data.col} + 4'd1;
      ramp_step = dctq_pkg::STEP_W'(rc_sum) * level_x + 15'd1;
      diff      = (req_data.row > req_data.col) ? req_data.row - req_data.col
                                                : req_data.col - req_data.row;
      case (table_kind_ff)
         dctq_pkg::KIND_LUMA:  step = luma_step;
         dctq_pkg::KIND_RAMP:  step = ramp_step;
         dctq_pkg::KIND_FLAT:  step = level_x;
         default:              step = (diff <= 3'd1) ? level_x : '0;
      endcase

      vld_in[0] = req_valid;
      neg_in[0] = req_data.coefficient[dctq_pkg::COEF_W-1];
      rem_in[0] = neg_in[0] ? MW'(0) - {req_data.coefficient[dctq_pkg::COEF_W-1],
                                        req_data.coefficient}
                            : {1'b0, req_data.coefficient};
      quo_in[0] = '0;
      den_in[0] = DEN_W'(step) << FRACTION_BITS;
   end

   // divide stages, DIV_BITS restoring steps each, quotient MSB first
   for (genvar k = 1; k <= NS; k++) begin : g_div
      localparam int BIT_HI = QW - 1 - (k - 1) * dctq_pkg::DIV_BITS;

      always_comb begin
         logic [MW-1:0]    rem;
         logic [QW-1:0]    quo;
         logic [CMP_W-1:0] shifted;

         rem = rem_ff[k-1];
         quo = quo_ff[k-1];
         for (int j = 0; j < dctq_pkg::DIV_BITS; j++) begin
            shifted = CMP_W'(den_ff[k-1]) << (BIT_HI - j);
            if (CMP_W'(rem) >= shifted) begin
               rem              = rem - MW'(shifted);
               quo[BIT_HI - j]  = 1'b1;
            end
         end
         vld_in[k] = vld_ff[k-1];
         rem_in[k] = rem;
         quo_in[k] = quo;
         den_in[k] = den_ff[k-1];
         neg_in[k] = neg_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= NS; k++) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            vld_ff[k] <= vld_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= NS; k++) begin
         if (rdy[k]) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
            den_ff[k] <= den_in[k];
            neg_ff[k] <= neg_in[k];
         end
      end
   end

   // output stage: round half to even, then saturate
   always_comb begin
      logic [CMP_W-1:0] rem_x;
      logic [CMP_W-1:0] den_x;
      logic [CMP_W-1:0] twice;
      logic             too_big;
      logic             zero_step;
      logic             up;
      logic [QW:0]      qr;

      rem_x     = CMP_W'(rem_ff[NS]);
      den_x     = CMP_W'(den_ff[NS]);
      twice     = rem_x << 1;
      zero_step = (den_ff[NS] == '0);
      // remainder still at least the divisor: quotient overran QUO_W bits
      too_big   = (rem_x >= den_x);
      up        = (twice > den_x) || ((twice == den_x) && quo_ff[NS][0]);
      qr        = {1'b0, quo_ff[NS]} + (QW+1)'(up);

      rsp_valid_in = vld_ff[NS];
      if (zero_step) begin
         rsp_in.overflow  = 1'b1;
         rsp_in.quantized = (rem_ff[NS] == '0) ? 8'sd0 :
                            (neg_ff[NS] ? -8'sd128 : 8'sd127);
      end else if (neg_ff[NS]) begin
         if (too_big || qr > dctq_pkg::QNT_NEG_MAX) begin
            rsp_in.overflow  = 1'b1;
            rsp_in.quantized = -8'sd128;
         end else begin
            rsp_in.overflow  = 1'b0;
            rsp_in.quantized = dctq_pkg::QNT_W'((QW+1)'(0) - qr);
         end
      end else begin
         if (too_big || qr > dctq_pkg::QNT_POS_MAX) begin
            rsp_in.overflow  = 1'b1;
            rsp_in.quantized = 8'sd127;
         end else begin
            rsp_in.overflow  = 1'b0;
            rsp_in.quantized = dctq_pkg::QNT_W'(qr);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rdy[NS+1]) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[NS+1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `DCTQ_ASSERT_ALWAYS(a_empty_after_reset, $past(reset) |-> !rsp_valid,
      "rsp_valid high right after reset")
   `DCTQ_ASSERT(a_bubble_takes_beat, !vld_ff[0] |-> !req_stall,
      "input stalled although the first stage is empty")
   `DCTQ_ASSERT(a_accept_fills_stage0, (req_valid && !req_stall) |=> vld_ff[0],
      "accepted beat did not reach the first stage")
   `DCTQ_ASSERT(a_overflow_at_rail,
      (rsp_valid && rsp_data.overflow) |->
         (rsp_data.quantized == 8'sd127 || rsp_data.quantized == -8'sd128 ||
          rsp_data.quantized == 8'sd0),
      "overflow flagged with a value off the rails")

endmodule
